>>> sv/first_fit_block_allocator_defines.svh
// Assertion macros used by the allocator datapath.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define FFBA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that holds in the same cycle as the trigger.
`define FFBA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence that holds in the cycle after the trigger.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ffba_pkg.sv
// Shared constants, status codes and controller/datapath interface types.
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int unsigned PoolBytesDef   = 4096;
  localparam int unsigned AllocHeaderDef = 16;
  localparam int unsigned FreeHeaderDef  = 16;
  localparam int unsigned MaxSegmentsDef = 256;

  localparam int unsigned ReqSizeW = 13;
  localparam int unsigned OffsetW  = 12;
  localparam int unsigned StatusW  = 2;

  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_NOMEM   = 2'd1;
  localparam logic [StatusW-1:0] ST_BADFREE = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic init;
    logic load;
    logic step;
    logic take;
    logic wr_alloc;
    logic su_rd;
    logic su_wr;
    logic wr_split;
    logic rd_right;
    logic take_right;
    logic wr_merge;
    logic sd_rd;
    logic sd_wr;
    logic sd_end;
    logic set_nomem;
    logic set_bad;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic req_free;
    logic early_bad;
    logic idx_end;
    logic fit;
    logic match;
    logic rd_use;
    logic has_right;
    logic split;
    logic su_more;
    logic sd_more;
    logic out_free;
  } dp_sts_t;

endpackage

>>> sv/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ffba_ctrl.sv
// Sequencer for scan, split, merge and table shifts.
`timescale 1ns / 1ps
module ffba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  ffba_pkg::dp_sts_t sts,
  output ffba_pkg::dp_cmd_t cmd
);
  import ffba_pkg::*;

  typedef enum logic [14:0] {
    S_INIT    = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_RD      = 15'b000000000000100,
    S_CHK     = 15'b000000000001000,
    S_A_HIT   = 15'b000000000010000,
    S_SU_RD   = 15'b000000000100000,
    S_SU_WR   = 15'b000000001000000,
    S_SPLIT   = 15'b000000010000000,
    S_F_RD    = 15'b000000100000000,
    S_F_RIGHT = 15'b000001000000000,
    S_MERGE   = 15'b000010000000000,
    S_SD_RD   = 15'b000100000000000,
    S_SD_WR   = 15'b001000000000000,
    S_DONE    = 15'b010000000000000,
    S_SPARE   = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = (state == S_IDLE);
    unique case (state)
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (sts.early_bad) begin
          cmd.set_bad = 1'b1;
          state_next  = S_DONE;
        end else if (sts.idx_end) begin
          if (sts.req_free) cmd.set_bad = 1'b1;
          else cmd.set_nomem = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (!sts.req_free) begin
          if (sts.fit) begin
            cmd.take   = 1'b1;
            state_next = S_A_HIT;
          end else begin
            cmd.step   = 1'b1;
            state_next = S_RD;
          end
        end else if (sts.match) begin
          if (!sts.rd_use) begin
            cmd.set_bad = 1'b1;
            state_next  = S_DONE;
          end else begin
            cmd.take   = 1'b1;
            state_next = sts.has_right ? S_F_RD : S_MERGE;
          end
        end else begin
          cmd.step   = 1'b1;
          state_next = S_RD;
        end
      end
      S_A_HIT: begin
        cmd.wr_alloc = 1'b1;
        state_next   = sts.split ? S_SU_RD : S_DONE;
      end
      S_SU_RD: begin
        if (sts.su_more) begin
          cmd.su_rd  = 1'b1;
          state_next = S_SU_WR;
        end else begin
          state_next = S_SPLIT;
        end
      end
      S_SU_WR: begin
        cmd.su_wr  = 1'b1;
        state_next = S_SU_RD;
      end
      S_SPLIT: begin
        cmd.wr_split = 1'b1;
        state_next   = S_DONE;
      end
      S_F_RD: begin
        cmd.rd_right = 1'b1;
        state_next   = S_F_RIGHT;
      end
      S_F_RIGHT: begin
        cmd.take_right = 1'b1;
        state_next     = S_MERGE;
      end
      S_MERGE: begin
        cmd.wr_merge = 1'b1;
        state_next   = S_SD_RD;
      end
      S_SD_RD: begin
        if (sts.sd_more) begin
          cmd.sd_rd  = 1'b1;
          state_next = S_SD_WR;
        end else begin
          cmd.sd_end = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SD_WR: begin
        cmd.sd_wr  = 1'b1;
        state_next = S_SD_RD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

>>> sv/ffba_dp.sv
// Segment table, request registers, arithmetic and result register.
`timescale 1ns / 1ps
`include "first_fit_block_allocator_defines.svh"
module ffba_dp #(
  parameter int unsigned POOL_BYTES   = ffba_pkg::PoolBytesDef,
  parameter int unsigned ALLOC_HEADER = ffba_pkg::AllocHeaderDef,
  parameter int unsigned FREE_HEADER  = ffba_pkg::FreeHeaderDef,
  parameter int unsigned MAX_SEGMENTS = ffba_pkg::MaxSegmentsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ffba_pkg::ReqSizeW-1:0] in_size,
  input  logic [ffba_pkg::OffsetW-1:0]  in_off,
  input  logic                          in_type,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [ffba_pkg::OffsetW-1:0]  m_off,
  output logic [ffba_pkg::StatusW-1:0]  m_status,
  input  ffba_pkg::dp_cmd_t             cmd,
  output ffba_pkg::dp_sts_t             sts
);
  import ffba_pkg::*;

  localparam int unsigned LW = $clog2(POOL_BYTES + 1);
  localparam int unsigned NW = ((LW > ReqSizeW) ? LW : ReqSizeW) + 1;
  localparam int unsigned TW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned EW = 2 * LW + 1;

  // Request and walk registers
  logic                req_type;
  logic [ReqSizeW-1:0] req_size;
  logic [OffsetW-1:0]  free_off;
  logic [TW-1:0]       total, idx, k;
  logic [1:0]          dcnt;
  logic [EW-1:0]       prev, cur, right;
  logic                right_free;
  logic [StatusW-1:0]  res_status;
  logic [OffsetW-1:0]  res_off;

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  ffba_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_tab (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Field views
  logic [LW-1:0] rd_start, rd_len, cur_start, cur_len, prev_start, prev_len, right_len;
  logic          rd_use, prev_use;
  assign rd_start   = rdata[LW-1:0];
  assign rd_len     = rdata[2*LW-1:LW];
  assign rd_use     = rdata[2*LW];
  assign cur_start  = cur[LW-1:0];
  assign cur_len    = cur[2*LW-1:LW];
  assign prev_start = prev[LW-1:0];
  assign prev_len   = prev[2*LW-1:LW];
  assign prev_use   = prev[2*LW];
  assign right_len  = right[2*LW-1:LW];

  // Fit and match arithmetic
  logic [NW-1:0]      need, rem_w, user_w, split_start_w;
  logic [LW-1:0]      rem, merge_len, rlen;
  logic [OffsetW-1:0] head;
  logic               split, left_free;
  logic [TW:0]        idx_p1, k_pd;

  assign need          = NW'(req_size) + NW'(ALLOC_HEADER);
  assign rem_w         = NW'(cur_len) - need;
  assign rem           = rem_w[LW-1:0];
  assign user_w        = NW'(cur_start) + NW'(ALLOC_HEADER);
  assign split_start_w = NW'(cur_start) + need;
  assign head          = free_off - OffsetW'(ALLOC_HEADER);
  assign split         = (rem > LW'(FREE_HEADER)) && (rem > LW'(ALLOC_HEADER))
                         && (total < TW'(MAX_SEGMENTS));
  assign left_free     = (idx != '0) && !prev_use;
  assign idx_p1        = (TW+1)'(idx) + (TW+1)'(1);
  assign k_pd          = (TW+1)'(k) + (TW+1)'(dcnt);
  assign rlen          = right_free ? right_len : '0;
  assign merge_len     = left_free ? (prev_len + cur_len + rlen) : (cur_len + rlen);

  // Status toward the controller
  always_comb begin
    sts.req_free  = (req_type == REQ_FREE);
    sts.early_bad = (req_type == REQ_FREE) && (free_off < OffsetW'(ALLOC_HEADER));
    sts.idx_end   = (idx == total);
    sts.fit       = !rd_use && (NW'(rd_len) >= need);
    sts.match     = (NW'(rd_start) == NW'(head));
    sts.rd_use    = rd_use;
    sts.has_right = idx_p1 < (TW+1)'(total);
    sts.split     = split;
    sts.su_more   = (TW+1)'(k) > idx_p1;
    sts.sd_more   = (dcnt != 2'd0) && (k_pd < (TW+1)'(total));
    sts.out_free  = !m_tvalid || m_tready;
  end

  // Table write and read address selection
  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = '0;
    raddr = idx[AW-1:0];
    if (cmd.init) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {1'b0, LW'(POOL_BYTES), LW'(0)};
    end else if (cmd.wr_alloc) begin
      we    = 1'b1;
      wdata = {1'b1, (split ? need[LW-1:0] : cur_len), cur_start};
    end else if (cmd.su_wr || cmd.sd_wr) begin
      we    = 1'b1;
      waddr = k[AW-1:0];
      wdata = rdata;
    end else if (cmd.wr_split) begin
      we    = 1'b1;
      waddr = idx_p1[AW-1:0];
      wdata = {1'b0, rem, split_start_w[LW-1:0]};
    end else if (cmd.wr_merge) begin
      we = 1'b1;
      if (left_free) begin
        waddr = idx[AW-1:0] - AW'(1);
        wdata = {1'b0, merge_len, prev_start};
      end else begin
        wdata = {1'b0, merge_len, cur_start};
      end
    end
    if (cmd.su_rd) begin
      raddr = k[AW-1:0] - AW'(1);
    end else if (cmd.rd_right) begin
      raddr = idx_p1[AW-1:0];
    end else if (cmd.sd_rd) begin
      raddr = k_pd[AW-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= TW'(1);
      idx      <= '0;
      k        <= '0;
      dcnt     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.init) total <= TW'(1);
      if (cmd.load) idx <= '0;
      if (cmd.step) idx <= idx + TW'(1);
      if (cmd.wr_alloc) k <= total;
      if (cmd.su_wr) k <= k - TW'(1);
      if (cmd.wr_split) total <= total + TW'(1);
      if (cmd.wr_merge) begin
        if (left_free) begin
          k    <= idx;
          dcnt <= 2'd1 + {1'b0, right_free};
        end else begin
          k    <= idx + TW'(1);
          dcnt <= {1'b0, right_free};
        end
      end
      if (cmd.sd_wr) k <= k + TW'(1);
      if (cmd.sd_end) total <= total - TW'(dcnt);
      if (cmd.emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type   <= in_type;
      req_size   <= in_size;
      free_off   <= in_off;
      res_status <= ST_OK;
      res_off    <= '0;
    end
    if (cmd.step) prev <= rdata;
    if (cmd.take) begin
      cur        <= rdata;
      right_free <= 1'b0;
    end
    if (cmd.take_right) begin
      right      <= rdata;
      right_free <= !rd_use;
    end
    if (cmd.wr_alloc) res_off <= user_w[OffsetW-1:0];
    if (cmd.set_nomem) res_status <= ST_NOMEM;
    if (cmd.set_bad) res_status <= ST_BADFREE;
    if (cmd.emit) begin
      m_status <= res_status;
      m_off    <= res_off;
    end
  end

  `FFBA_ASSERT_ALWAYS(a_total_range, (total != '0) && (total <= TW'(MAX_SEGMENTS)), "segment count out of range")
  `FFBA_ASSERT_NEXT(a_emit_valid, cmd.emit, m_tvalid, "result not presented after emit")
  `FFBA_ASSERT_IMPLY(a_shift_bound, cmd.su_wr || cmd.sd_wr, k < TW'(MAX_SEGMENTS), "shift index beyond table")
  `FFBA_ASSERT_IMPLY(a_split_room, cmd.wr_split, total < TW'(MAX_SEGMENTS), "split with full table")

endmodule

>>> sv/first_fit_block_allocator.sv
// Top level: first-fit allocator over a segment table with coalescing on free.
// Each request scans the table from entry 0; an allocation that splits shifts later
// entries up, and a free that merges shifts later entries down.
// Requests are handled one at a time: s_tready is high only in the idle state.
// Reset (rst, synchronous): the controller enters S_INIT, which writes the whole-pool free segment to entry 0.
// The output register holds a result while the next request is taken.
`timescale 1ns / 1ps
module first_fit_block_allocator #(
  parameter int unsigned POOL_BYTES   = ffba_pkg::PoolBytesDef,
  parameter int unsigned ALLOC_HEADER = ffba_pkg::AllocHeaderDef,
  parameter int unsigned FREE_HEADER  = ffba_pkg::FreeHeaderDef,
  parameter int unsigned MAX_SEGMENTS = ffba_pkg::MaxSegmentsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [12:0] req_size, [24:13] free_offset, rest zero
  input  logic        s_tuser,  // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [11:0] user_offset, rest zero
  output logic [1:0]  m_tuser   // [1:0] status
);
  import ffba_pkg::*;

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [OffsetW-1:0] m_off;

  ffba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  ffba_dp #(
    .POOL_BYTES  (POOL_BYTES),
    .ALLOC_HEADER(ALLOC_HEADER),
    .FREE_HEADER (FREE_HEADER),
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_size (s_tdata[12:0]),
    .in_off  (s_tdata[24:13]),
    .in_type (s_tuser),
    .m_tready(m_tready),
    .m_tvalid(m_tvalid),
    .m_off   (m_off),
    .m_status(m_tuser),
    .cmd     (cmd),
    .sts     (sts)
  );

  assign m_tdata = {4'b0, m_off};

endmodule
